[design/crg_pkg.sv]
package crg_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned ADDR_WIDTH = 5;

   // Reset values of the configuration registers and of both generator states
   localparam logic [WORD_WIDTH-1:0] LCG_MULT_RESET = 32'd1220703125;
   localparam logic [WORD_WIDTH-1:0] LCG_INC_RESET  = 32'd0;
   localparam logic [WORD_WIDTH-1:0] LCG_MOD_RESET  = 32'd2147483648;
   localparam logic [WORD_WIDTH-1:0] QCG_SQR_RESET  = 32'd2;
   localparam logic [WORD_WIDTH-1:0] QCG_LIN_RESET  = 32'd0;
   localparam logic [WORD_WIDTH-1:0] QCG_CON_RESET  = 32'd0;
   localparam logic [WORD_WIDTH-1:0] QCG_MOD_RESET  = 32'd46199;
   localparam logic [WORD_WIDTH-1:0] STATE_RESET    = 32'd32;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [1:0] {
      OP_ADVANCE_LINEAR    = 2'd0,
      OP_ADVANCE_QUADRATIC = 2'd1,
      OP_LOAD_LINEAR       = 2'd2,
      OP_LOAD_QUADRATIC    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_LCG_MULT = 3'd0,
      REG_LCG_INC  = 3'd1,
      REG_LCG_MOD  = 3'd2,
      REG_QCG_SQR  = 3'd3,
      REG_QCG_LIN  = 3'd4,
      REG_QCG_CON  = 3'd5,
      REG_QCG_MOD  = 3'd6,
      REG_NONE     = 3'd7
   } reg_index_type;

   // Status of a serial arithmetic unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

[design/crg_mul.sv]
module crg_mul
   import crg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  word_type        op_a,
   input  word_type        op_b,
   output unit_status_type status,
   output word_type        product
);

   localparam int unsigned CNT_WIDTH = $clog2(WORD_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(WORD_WIDTH - 1);

   word_type             acc_ff;
   word_type             mcand_ff;
   word_type             mplier_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Shift-and-add, one multiplier bit a cycle, keeping the low word only
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff    <= '0;
            mcand_ff  <= op_a;
            mplier_ff <= op_b;
            cnt_ff    <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[WORD_WIDTH-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[WORD_WIDTH-1:1]};
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

[design/crg_mod.sv]
module crg_mod
   import crg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  word_type        dividend,
   input  word_type        modulus,
   output unit_status_type status,
   output word_type        remainder
);

   localparam int unsigned CNT_WIDTH = $clog2(WORD_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(WORD_WIDTH - 1);

   word_type             rem_ff;
   word_type             quo_ff;
   word_type             mod_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [WORD_WIDTH:0]  shifted;
   logic [WORD_WIDTH:0]  diff;

   // Bring down the next dividend bit and try the subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_WIDTH-1]};
      diff    = shifted - {1'b0, mod_ff};
   end

   // Restoring reduction, one dividend bit a cycle; a zero modulus keeps the value
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mod_ff <= modulus;
            cnt_ff <= '0;
            if (modulus == '0) begin
               rem_ff  <= dividend;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= '0;
               quo_ff  <= dividend;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (!diff[WORD_WIDTH]) begin
               rem_ff <= diff[WORD_WIDTH-1:0];
            end else begin
               rem_ff <= shifted[WORD_WIDTH-1:0];
            end
            quo_ff <= {quo_ff[WORD_WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

[design/congruential_random_generators.sv]
// Two 32-bit congruential generators, linear and quadratic, sharing one bit-serial
// multiplier and one bit-serial reducer. A request carries an operation in tuser and a
// seed in tdata; an advance returns the new state with a flag telling which generator
// produced it, a load just replaces a state and returns nothing. Products and sums
// wrap at 32 bits before the reduction, and a modulus of zero keeps the wrapped value.
// A linear advance runs one multiplication and a quadratic one runs two, followed
// by one reduction; with a zero modulus the reducer finishes without iterating. The
// multiplier and reducer each retire one bit a cycle. The result sits in an output
// register, so a new request is taken while it waits.
module congruential_random_generators
   import crg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] seed_value
   input  logic [1:0]            req_tuser,   // [1:0] operation
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] random_value
   output logic                  rsp_tuser,   // [0] from_quadratic
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MOD,
      S_PUT
   } state_type;

   state_type       state_ff, state_in;
   word_type        lcg_mult_ff, lcg_inc_ff, lcg_mod_ff;
   word_type        qcg_sqr_ff, qcg_lin_ff, qcg_con_ff, qcg_mod_ff;
   word_type        lin_state_ff, lin_state_in;
   word_type        quad_state_ff, quad_state_in;
   logic            is_quad_ff, is_quad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   word_type        rsp_data_ff, rsp_data_in;
   logic            rsp_quad_ff, rsp_quad_in;

   logic            req_accept;
   op_type          req_op;
   reg_index_type   csr_index;
   logic            csr_write;

   logic            mul_start;
   word_type        mul_a, mul_b, mul_product;
   unit_status_type mul_stat;
   logic            mod_start;
   word_type        mod_value, mod_modulus, mod_result;
   unit_status_type mod_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_WIDTH-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Return the addressed register
   always_comb begin
      case (csr_index)
         REG_LCG_MULT: csr_prdata = lcg_mult_ff;
         REG_LCG_INC:  csr_prdata = lcg_inc_ff;
         REG_LCG_MOD:  csr_prdata = lcg_mod_ff;
         REG_QCG_SQR:  csr_prdata = qcg_sqr_ff;
         REG_QCG_LIN:  csr_prdata = qcg_lin_ff;
         REG_QCG_CON:  csr_prdata = qcg_con_ff;
         REG_QCG_MOD:  csr_prdata = qcg_mod_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // Hold the configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_mult_ff <= LCG_MULT_RESET;
         lcg_inc_ff  <= LCG_INC_RESET;
         lcg_mod_ff  <= LCG_MOD_RESET;
         qcg_sqr_ff  <= QCG_SQR_RESET;
         qcg_lin_ff  <= QCG_LIN_RESET;
         qcg_con_ff  <= QCG_CON_RESET;
         qcg_mod_ff  <= QCG_MOD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LCG_MULT: lcg_mult_ff <= csr_pwdata;
            REG_LCG_INC:  lcg_inc_ff  <= csr_pwdata;
            REG_LCG_MOD:  lcg_mod_ff  <= csr_pwdata;
            REG_QCG_SQR:  qcg_sqr_ff  <= csr_pwdata;
            REG_QCG_LIN:  qcg_lin_ff  <= csr_pwdata;
            REG_QCG_CON:  qcg_con_ff  <= csr_pwdata;
            REG_QCG_MOD:  qcg_mod_ff  <= csr_pwdata;
            default:      ;
         endcase
      end
   end

   // Sequence the shared units: the quadratic term is taken as x*(q*x + l) + k
   always_comb begin
      state_in      = state_ff;
      lin_state_in  = lin_state_ff;
      quad_state_in = quad_state_ff;
      is_quad_in    = is_quad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_quad_in   = rsp_quad_ff;
      mul_start     = 1'b0;
      mul_a         = lcg_mult_ff;
      mul_b         = lin_state_ff;
      mod_start     = 1'b0;
      mod_value     = mul_product + lcg_inc_ff;
      mod_modulus   = lcg_mod_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_ADVANCE_LINEAR: begin
                     mul_start  = 1'b1;
                     is_quad_in = 1'b0;
                     state_in   = S_MUL1;
                  end
                  OP_ADVANCE_QUADRATIC: begin
                     mul_start  = 1'b1;
                     mul_a      = qcg_sqr_ff;
                     mul_b      = quad_state_ff;
                     is_quad_in = 1'b1;
                     state_in   = S_MUL1;
                  end
                  OP_LOAD_LINEAR:    lin_state_in  = req_tdata;
                  OP_LOAD_QUADRATIC: quad_state_in = req_tdata;
                  default:           ;
               endcase
            end
         end
         S_MUL1: begin
            if (mul_stat.done) begin
               if (is_quad_ff) begin
                  mul_start = 1'b1;
                  mul_a     = mul_product + qcg_lin_ff;
                  mul_b     = quad_state_ff;
                  state_in  = S_MUL2;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_MUL2: begin
            mod_value   = mul_product + qcg_con_ff;
            mod_modulus = qcg_mod_ff;
            if (mul_stat.done) begin
               mod_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_stat.done) begin
               if (is_quad_ff) begin
                  quad_state_in = mod_result;
               end else begin
                  lin_state_in = mod_result;
               end
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            // Wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mod_result;
               rsp_quad_in  = is_quad_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, generator states and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         lin_state_ff  <= STATE_RESET;
         quad_state_ff <= STATE_RESET;
         is_quad_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lin_state_ff  <= lin_state_in;
         quad_state_ff <= quad_state_in;
         is_quad_ff    <= is_quad_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_quad_ff <= rsp_quad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_quad_ff;

   crg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .status  (mul_stat),
      .product (mul_product)
   );

   crg_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_value),
      .modulus   (mod_modulus),
      .status    (mod_stat),
      .remainder (mod_result)
   );

`ifndef SYNTHESIS
   // Multiplier finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == S_MUL1 || state_ff == S_MUL2))
      else $error("multiplier finished outside a multiply step");

   // Reducer finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mod_stat.done |-> (state_ff == S_MOD))
      else $error("reducer finished outside the reduction step");

   // The two serial units never run at once
   assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && mod_stat.busy))
      else $error("multiplier and reducer busy together");

   // A load never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_LOAD_LINEAR || req_op == OP_LOAD_QUADRATIC))
      |=> (state_ff == S_IDLE))
      else $error("load request left the sequencer busy");

   // A new result enters the output register only from the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_PUT))
      else $error("result raised outside the output step");
`endif

endmodule

[sim/tb_congruential_random_generators.sv]
module tb_congruential_random_generators;
   import crg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 128;   // longer than the slowest advance
   localparam int STALL_LIMIT   = 4000;  // cycles with no request or result taken
   localparam int RANDOM_PHASES = 12;
   localparam int RANDOM_ITEMS  = 1830;
   localparam int STEADY_PHASE  = 4;     // phase run with no idling on either side

   typedef struct {
      op_type   operation;
      word_type seed_value;
   } request_item;

   typedef struct {
      word_type random_value;
      logic     from_quadratic;
   } generator_result;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;   // [31:0] seed_value
   logic [1:0]            req_tuser   = '0;   // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;          // [31:0] random_value
   logic                  rsp_tuser;          // [0] from_quadratic
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor copy of the registers and of both generator states
   word_type csr_model [7] = '{LCG_MULT_RESET, LCG_INC_RESET, LCG_MOD_RESET,
                               QCG_SQR_RESET, QCG_LIN_RESET, QCG_CON_RESET,
                               QCG_MOD_RESET};
   word_type linear_model    = STATE_RESET;
   word_type quadratic_model = STATE_RESET;

   request_item     pending_requests [$];
   generator_result expected_values [$];
   int              failures      = 0;
   int              stall_cycles  = 0;
   bit              steady_traffic = 1'b0;

   congruential_random_generators DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A zero modulus stands for 2^32: keep the wrapped value
   function automatic word_type reduce_word(word_type value, word_type modulus);
      return (modulus == '0) ? value : value % modulus;
   endfunction

   // Apply one accepted request to the generator copies, queue any new value
   function automatic void step_generators(op_type operation, word_type seed);
      word_type x;
      word_type t;
      case (operation)
         OP_ADVANCE_LINEAR: begin
            x = linear_model;
            t = csr_model[REG_LCG_MULT] * x + csr_model[REG_LCG_INC];
            linear_model = reduce_word(t, csr_model[REG_LCG_MOD]);
            expected_values.push_back('{random_value: linear_model, from_quadratic: 1'b0});
         end
         OP_ADVANCE_QUADRATIC: begin
            x = quadratic_model;
            t = csr_model[REG_QCG_SQR] * x * x + csr_model[REG_QCG_LIN] * x
                + csr_model[REG_QCG_CON];
            quadratic_model = reduce_word(t, csr_model[REG_QCG_MOD]);
            expected_values.push_back('{random_value: quadratic_model, from_quadratic: 1'b1});
         end
         OP_LOAD_LINEAR:    linear_model = seed;
         OP_LOAD_QUADRATIC: quadratic_model = seed;
      endcase
   endfunction

   // Request driver: predict on acceptance, then offer the next pending request
   always @(posedge clock) begin
      request_item next_request;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_generators(op_type'(req_tuser), req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && (steady_traffic || $urandom_range(99) >= 17)) begin
               next_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_request.seed_value;
               req_tuser  <= next_request.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: hold back at random, compare each value with the oldest expectation
   always @(posedge clock) begin
      generator_result wanted;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_traffic || $urandom_range(99) >= 17;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $error("result with nothing expected: random_value %h from_quadratic %b",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               wanted = expected_values.pop_front();
               if (rsp_tdata !== wanted.random_value) begin
                  $error("random_value: expected %h, got %h", wanted.random_value, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser !== wanted.from_quadratic) begin
                  $error("from_quadratic: expected %b, got %b", wanted.from_quadratic,
                         rsp_tuser);
                  failures++;
               end
            end
         end
      end
   end

   // Count cycles without any request or result taken
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("[congruential_random_generators] ERROR");
      $finish;
   end

   // Register write: setup cycle, then access cycle until pready
   task automatic csr_write(reg_index_type index, word_type value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index != REG_NONE) csr_model[index] = value;
   endtask

   task automatic add_request(op_type operation, word_type seed);
      pending_requests.push_back('{operation: operation, seed_value: seed});
   endtask

   // Wait for every request to go in and every value to come out, then let the block settle
   task automatic drain_block();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_values.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return $urandom_range(1000, 2);
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type pick_seed();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(100);
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_operation();
      int roll;
      roll = $urandom_range(99);
      if (roll < 38) return OP_ADVANCE_LINEAR;
      if (roll < 76) return OP_ADVANCE_QUADRATIC;
      if (roll < 88) return OP_LOAD_LINEAR;
      return OP_LOAD_QUADRATIC;
   endfunction

   initial begin
      int per_phase;
      word_type value;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: both advances, seed ignored on advance, seeds just below and past modulus
      add_request(OP_ADVANCE_LINEAR, '0);
      add_request(OP_ADVANCE_LINEAR, '1);
      add_request(OP_ADVANCE_QUADRATIC, '0);
      add_request(OP_ADVANCE_QUADRATIC, '1);
      add_request(OP_LOAD_LINEAR, '1);
      add_request(OP_ADVANCE_LINEAR, '0);
      add_request(OP_LOAD_QUADRATIC, '1);
      add_request(OP_ADVANCE_QUADRATIC, '0);
      add_request(OP_LOAD_LINEAR, '0);
      add_request(OP_ADVANCE_LINEAR, '1);
      add_request(OP_LOAD_QUADRATIC, '0);
      add_request(OP_ADVANCE_QUADRATIC, '1);
      add_request(OP_LOAD_QUADRATIC, 32'd46198);
      add_request(OP_ADVANCE_QUADRATIC, '0);
      drain_block();

      // Zero moduli, all-ones coefficients, and a write to the unused index
      csr_write(REG_NONE, '1);
      csr_write(REG_LCG_MULT, '1);
      csr_write(REG_LCG_INC, '1);
      csr_write(REG_LCG_MOD, '0);
      csr_write(REG_QCG_SQR, '1);
      csr_write(REG_QCG_LIN, '1);
      csr_write(REG_QCG_CON, '1);
      csr_write(REG_QCG_MOD, '0);
      @(negedge clock);
      add_request(OP_LOAD_LINEAR, '1);
      add_request(OP_ADVANCE_LINEAR, '0);
      add_request(OP_ADVANCE_LINEAR, '0);
      add_request(OP_LOAD_QUADRATIC, '1);
      add_request(OP_ADVANCE_QUADRATIC, '0);
      add_request(OP_ADVANCE_QUADRATIC, '0);
      add_request(OP_LOAD_QUADRATIC, 32'h8000_0001);
      add_request(OP_ADVANCE_QUADRATIC, '1);
      drain_block();

      // Random phases: fresh settings each time, the first two at the extremes
      per_phase = RANDOM_ITEMS / RANDOM_PHASES;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int index = 0; index < 7; index++) begin
            if (phase == 0) value = '1;
            else if (phase == 1) value = '0;
            else value = pick_word();
            csr_write(reg_index_type'(index), value);
         end
         @(negedge clock);
         steady_traffic = (phase == STEADY_PHASE);
         for (int item = 0; item < per_phase; item++) begin
            add_request(pick_operation(), pick_seed());
         end
         drain_block();
      end
      steady_traffic = 1'b0;

      if (failures == 0 && expected_values.size() == 0) begin
         $display("[congruential_random_generators] OK");
      end else begin
         $display("[congruential_random_generators] ERROR");
      end
      $finish;
   end

endmodule
